### src/tick_priority_counter_scheduler_top_macros.svh
// assertion macros for the scheduler datapath
`ifndef TICK_PRIORITY_COUNTER_SCHEDULER_TOP_MACROS_SVH
`define TICK_PRIORITY_COUNTER_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define TPCS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tpcs_pkg.sv
// types, constants and controller codes of the tick scheduler
package tpcs_pkg;

   localparam int NUM_TASKS   = 8;
   localparam int TASK_W      = 3;
   localparam int SLICE_W     = 4;
   localparam int IDX_W       = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;
   localparam int CFG_REGS    = 7;
   localparam int CFG_IDX_W   = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam logic [SLICE_W-1:0] PRIO_RESET = SLICE_W'(1);

   typedef logic [CFG_REGS-1:0][SLICE_W-1:0] prio_array_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ANY,
      ST_FIND,
      ST_COMMIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic hold_res;
      logic wr_dec;
      logic sched_start;
      logic any_step;
      logic find_start;
      logic find_step;
      logic idx_inc;
      logic commit;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic tick;
      logic run_idle;
      logic dec_zero;
      logic idx_last;
      logic out_free;
   } status_type;

endpackage

### src/tpcs_if.sv
// valid/ready channels for tick beats and scheduler results
interface tpcs_req_if import tpcs_pkg::*; ();
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

interface tpcs_rsp_if import tpcs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TASK_W-1:0]    running_task;
   logic                 switched;
   logic                 reloaded;
   logic [SLICE_W-1:0]   slice_left;

   modport source (output valid, output running_task, output switched,
                   output reloaded, output slice_left, input ready);
   modport sink (input valid, input running_task, input switched,
                 input reloaded, input slice_left, output ready);
endinterface

### src/tpcs_csr.sv
// apb priority registers for tasks one and up
module tpcs_csr import tpcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output prio_array_type        prio
);

   prio_array_type        prio_ff;
   logic [CFG_IDX_W-1:0]  reg_idx;
   logic                  reg_hit;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign reg_hit    = (int'(reg_idx) < CFG_REGS);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && reg_hit;
   assign csr_pready = 1'b1;
   assign prio       = prio_ff;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(prio_ff[reg_idx]) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CFG_REGS; i++) begin
            prio_ff[i] <= PRIO_RESET;
         end
      end else if (wr_en) begin
         prio_ff[reg_idx] <= csr_pwdata[SLICE_W-1:0];
      end
   end

endmodule

### src/tpcs_ctrl.sv
// sequencer for decrement, counter scans and result hand-off
module tpcs_ctrl import tpcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.tick) begin
               cmd.hold_res = 1'b1;
               state_in     = ST_EMIT;
            end else if (status.run_idle) begin
               cmd.sched_start = 1'b1;
               state_in        = ST_ANY;
            end else begin
               cmd.wr_dec = 1'b1;
               if (status.dec_zero) begin
                  cmd.sched_start = 1'b1;
                  state_in        = ST_ANY;
               end else begin
                  cmd.hold_res = 1'b1;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_ANY: begin
            cmd.any_step = 1'b1;
            if (status.idx_last) begin
               cmd.find_start = 1'b1;
               state_in       = ST_FIND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_FIND: begin
            cmd.find_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### src/tpcs_dp.sv
// slice counters, scan registers and result register
module tpcs_dp import tpcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  prio_array_type      prio,
   input  logic                req_tick,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [TASK_W-1:0]   rsp_running_task,
   output logic                rsp_switched,
   output logic                rsp_reloaded,
   output logic [SLICE_W-1:0]  rsp_slice_left
);

   localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_TASKS - 1);

   logic [SLICE_W-1:0] cnt_ff [NUM_TASKS];
   logic [IDX_W-1:0]   running_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               tick_ff;
   logic               any_ff;
   logic [IDX_W-1:0]   best_ff;
   logic [SLICE_W-1:0] bval_ff;
   logic [IDX_W-1:0]   res_task_ff;
   logic               res_sw_ff;
   logic               res_rl_ff;
   logic [SLICE_W-1:0] res_slice_ff;
   logic               out_valid_ff;
   logic [TASK_W-1:0]  out_task_ff;
   logic               out_sw_ff;
   logic               out_rl_ff;
   logic [SLICE_W-1:0] out_slice_ff;

   logic [SLICE_W-1:0]   rd;
   logic [SLICE_W-1:0]   dec;
   logic [CFG_IDX_W-1:0] pidx;
   logic [SLICE_W-1:0]   cand;
   logic                 cnt_we;
   logic [SLICE_W-1:0]   cnt_wdata;
   logic                 out_free;

   assign rd        = cnt_ff[idx_ff];
   assign dec       = (rd != '0) ? rd - SLICE_W'(1) : rd;
   assign pidx      = CFG_IDX_W'(idx_ff) - CFG_IDX_W'(1);
   assign cand      = any_ff ? rd : prio[pidx];
   assign cnt_we    = cmd.wr_dec || (cmd.find_step && !any_ff);
   assign cnt_wdata = cmd.wr_dec ? dec : prio[pidx];
   assign out_free  = !out_valid_ff || rsp_ready;

   assign status.tick     = tick_ff;
   assign status.run_idle = (running_ff == '0);
   assign status.dec_zero = (dec == '0);
   assign status.idx_last = (idx_ff == IDX_LAST);
   assign status.out_free = out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_running_task = out_task_ff;
   assign rsp_switched     = out_sw_ff;
   assign rsp_reloaded     = out_rl_ff;
   assign rsp_slice_left   = out_slice_ff;

   // counters, running task and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            cnt_ff[i] <= '0;
         end
         running_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cnt_we) begin
            cnt_ff[idx_ff] <= cnt_wdata;
         end
         if (cmd.commit) begin
            running_ff <= best_ff;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // scan and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         tick_ff <= req_tick;
         idx_ff  <= running_ff;
      end else if (cmd.sched_start || cmd.find_start) begin
         idx_ff <= IDX_FIRST;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.sched_start) begin
         any_ff <= 1'b0;
      end else if (cmd.any_step) begin
         any_ff <= any_ff || (rd != '0);
      end
      if (cmd.find_start) begin
         best_ff <= '0;
         bval_ff <= '0;
      end else if (cmd.find_step && (cand > bval_ff)) begin
         best_ff <= idx_ff;
         bval_ff <= cand;
      end
      if (cmd.hold_res) begin
         res_task_ff  <= running_ff;
         res_sw_ff    <= 1'b0;
         res_rl_ff    <= 1'b0;
         res_slice_ff <= tick_ff ? dec : rd;
      end else if (cmd.commit) begin
         res_task_ff  <= best_ff;
         res_sw_ff    <= (best_ff != running_ff);
         res_rl_ff    <= !any_ff;
         res_slice_ff <= bval_ff;
      end
      if (cmd.emit) begin
         out_task_ff  <= TASK_W'(res_task_ff);
         out_sw_ff    <= res_sw_ff;
         out_rl_ff    <= res_rl_ff;
         out_slice_ff <= res_slice_ff;
      end
   end

`include "tick_priority_counter_scheduler_top_macros.svh"

   `TPCS_ASSERT_IMPLY(a_idle_cnt_zero, clock, reset, 1'b1, cnt_ff[0] == '0, "idle counter nonzero")
   `TPCS_ASSERT_IMPLY(a_emit_free, clock, reset, cmd.emit, out_free, "result overwritten")
   `TPCS_ASSERT_NEXT(a_commit_run, clock, reset, cmd.commit, running_ff == $past(best_ff), "running not updated")
   `TPCS_ASSERT_IMPLY(a_zero_best_idle, clock, reset, cmd.commit && bval_ff == '0, best_ff == '0, "empty pick not idle")

endmodule

### src/tick_priority_counter_scheduler_top.sv
// top level of the tick-driven counter priority scheduler
//
//   channel   dir   beat
//   req_ch    in    tick
//   rsp_ch    out   running_task, switched, reloaded, slice_left
//   csr_*     in    apb access of priority_task1..7 at 4*(i-1)
//
// a beat without tick, or one whose decrement leaves a nonzero slice, goes from check to hand-off
// a beat that schedules makes two passes over the counters
// through one read port (any-nonzero pass, then reload-and-pick pass)
// one beat in flight; a waiting result holds only the final hand-off stage
// synchronous reset clears counters, running task and priorities (to one)
module tick_priority_counter_scheduler_top import tpcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tpcs_req_if.sink              req_ch,
   tpcs_rsp_if.source            rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   prio_array_type prio;
   cmd_type        cmd;
   status_type     status;

   tpcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .prio        (prio)
   );

   tpcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpcs_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .prio             (prio),
      .req_tick         (req_ch.tick),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_running_task (rsp_ch.running_task),
      .rsp_switched     (rsp_ch.switched),
      .rsp_reloaded     (rsp_ch.reloaded),
      .rsp_slice_left   (rsp_ch.slice_left)
   );

endmodule

### dv/tick_priority_counter_scheduler_top_tb.sv
// self-checking testbench for the tick priority counter scheduler top level
`timescale 1ns / 1ps

module tick_priority_counter_scheduler_top_tb;
   import tpcs_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RANDOM_BEATS   = 1600;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 2 * NUM_TASKS + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_CAP      = 100;
   localparam int PLAN_ROWS      = 23;

   typedef enum logic [2:0] {
      REG_PRIO_TASK1,
      REG_PRIO_TASK2,
      REG_PRIO_TASK3,
      REG_PRIO_TASK4,
      REG_PRIO_TASK5,
      REG_PRIO_TASK6,
      REG_PRIO_TASK7,
      REG_UNMAPPED
   } csr_reg_type;

   typedef enum logic [1:0] {ROW_BEAT, ROW_WRITE, ROW_FILL} row_kind_type;

   typedef enum logic [2:0] {
      CFG_RANDOM, CFG_ZERO, CFG_FULL, CFG_EDGES, CFG_SHORT
   } cfg_mode_type;

   typedef struct packed {
      logic [TASK_W-1:0]  run_task;
      logic               switched;
      logic               reloaded;
      logic [SLICE_W-1:0] slice;
   } sched_result_type;

   typedef struct packed {
      row_kind_type       kind;
      logic               tick;
      csr_reg_type        which;
      logic [SLICE_W-1:0] value;
      logic               typed;
      sched_result_type   want;
   } plan_row_type;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_BEAT,  1'b0, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b0, 4'd0}},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd1, 1'b1, 1'b1, 4'd1}},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd2, 1'b1, 1'b0, 4'd1}},
      '{ROW_BEAT,  1'b0, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd2, 1'b0, 1'b0, 4'd1}},
      '{ROW_FILL,  1'b0, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd0, 1'b1, 1'b1, 4'd0}},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b1, 4'd0}},
      '{ROW_BEAT,  1'b0, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd0, 1'b0, 1'b0, 4'd0}},
      '{ROW_FILL,  1'b0, REG_PRIO_TASK1, 4'd15, 1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd1, 1'b1, 1'b1, 4'd15}},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b1, '{3'd1, 1'b0, 1'b0, 4'd14}},
      '{ROW_WRITE, 1'b0, REG_UNMAPPED,   4'd0,  1'b0, '0},
      '{ROW_WRITE, 1'b0, REG_PRIO_TASK1, 4'd3,  1'b0, '0},
      '{ROW_WRITE, 1'b0, REG_PRIO_TASK3, 4'd0,  1'b0, '0},
      '{ROW_WRITE, 1'b0, REG_PRIO_TASK5, 4'd9,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b0, REG_PRIO_TASK1, 4'd0,  1'b0, '0},
      '{ROW_BEAT,  1'b1, REG_PRIO_TASK1, 4'd0,  1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tpcs_req_if req_ch ();
   tpcs_rsp_if rsp_ch ();

   tick_priority_counter_scheduler_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // scheduler state as the testbench tracks it
   logic [TASK_W-1:0]  run_model;
   logic [SLICE_W-1:0] slice_model [NUM_TASKS];
   logic [SLICE_W-1:0] prio_model [NUM_TASKS];

   sched_result_type   pending_results [$];
   logic               typed_flag;
   sched_result_type   typed_result;
   int                 results_seen = 0;
   int                 errors = 0;
   int                 quiet_cycles = 0;

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic reschedule();
      logic               any_live;
      logic [TASK_W-1:0]  best;
      logic [SLICE_W-1:0] best_val;
      any_live = 1'b0;
      best = '0;
      best_val = '0;
      for (int i = 1; i < NUM_TASKS; i++)
         if (slice_model[i] != 0) any_live = 1'b1;
      if (!any_live)
         for (int i = 1; i < NUM_TASKS; i++) slice_model[i] = prio_model[i];
      for (int i = 1; i < NUM_TASKS; i++) begin
         if (slice_model[i] > best_val) begin
            best_val = slice_model[i];
            best = TASK_W'(i);
         end
      end
      run_model = best;
      return !any_live;
   endfunction

   function automatic sched_result_type predict_tick(input logic tick);
      sched_result_type  res;
      logic [TASK_W-1:0] prior;
      logic              reload;
      prior = run_model;
      reload = 1'b0;
      if (tick) begin
         if (run_model == 0) begin
            reload = reschedule();
         end else begin
            if (slice_model[run_model] != 0)
               slice_model[run_model] = slice_model[run_model] - 1'b1;
            if (slice_model[run_model] == 0) reload = reschedule();
         end
      end
      res.run_task = run_model;
      res.switched = (run_model != prior);
      res.reloaded = reload;
      res.slice = slice_model[run_model];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
   endtask

   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = predict_tick(req_ch.tick);
            if (typed_flag) want = typed_result;
            pending_results.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result beat with nothing pending");
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.running_task !== want.run_task)
                  report_mismatch($sformatf("running_task %0d, want %0d",
                                            rsp_ch.running_task, want.run_task));
               if (rsp_ch.switched !== want.switched)
                  report_mismatch($sformatf("switched %0d, want %0d",
                                            rsp_ch.switched, want.switched));
               if (rsp_ch.reloaded !== want.reloaded)
                  report_mismatch($sformatf("reloaded %0d, want %0d",
                                            rsp_ch.reloaded, want.reloaded));
               if (rsp_ch.slice_left !== want.slice)
                  report_mismatch($sformatf("slice_left %0d, want %0d",
                                            rsp_ch.slice_left, want.slice));
            end
            results_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: bursts of ready, random stalls, one long hold-off
   initial begin : result_drain
      int  n;
      bit  held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
         n = gap_len();
         if (n != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   // entered and left at a falling edge; valid stays high into the next beat
   task automatic send_beat(input logic tick, input logic typed,
                            input sched_result_type want);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_flag = typed;
      typed_result = want;
      req_ch.tick = tick;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic prio_write(input csr_reg_type which, input logic [SLICE_W-1:0] value);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(4 * int'(which));
      csr_pwdata = $urandom;
      csr_pwdata[SLICE_W-1:0] = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (which != REG_UNMAPPED) prio_model[int'(which) + 1] = value;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   initial begin : stimulus
      cfg_mode_type       mode;
      int                 beats;
      int                 phase_len;
      logic [SLICE_W-1:0] v;
      req_ch.valid = 1'b0;
      req_ch.tick = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      typed_flag = 1'b0;
      typed_result = '0;
      run_model = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         slice_model[i] = '0;
         prio_model[i] = (i == 0) ? '0 : PRIO_RESET;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         case (PLAN[i].kind)
            ROW_BEAT: begin
               send_beat(PLAN[i].tick, PLAN[i].typed, PLAN[i].want);
            end
            ROW_WRITE: begin
               settle();
               prio_write(PLAN[i].which, PLAN[i].value);
            end
            default: begin
               settle();
               for (int r = REG_PRIO_TASK1; r <= REG_PRIO_TASK7; r++)
                  prio_write(csr_reg_type'(r), PLAN[i].value);
            end
         endcase
      end

      beats = 0;
      mode = CFG_RANDOM;
      while (beats < RANDOM_BEATS) begin
         // sender waits here until every result is back
         settle();
         for (int r = REG_PRIO_TASK1; r <= REG_PRIO_TASK7; r++) begin
            case (mode)
               CFG_RANDOM: v = SLICE_W'($urandom_range(0, 15));
               CFG_ZERO:   v = '0;
               CFG_FULL:   v = 4'd15;
               CFG_EDGES:  v = $urandom_range(0, 1) ? 4'd15 : 4'd0;
               default:    v = SLICE_W'($urandom_range(0, 2));
            endcase
            prio_write(csr_reg_type'(r), v);
         end
         if (mode == CFG_EDGES) prio_write(REG_UNMAPPED, SLICE_W'($urandom_range(0, 15)));
         phase_len = $urandom_range(20, 120);
         repeat (phase_len) send_beat($urandom_range(0, 99) < 85, 1'b0, '0);
         beats += phase_len;
         mode = (mode == CFG_SHORT) ? CFG_RANDOM : cfg_mode_type'(mode + 1);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
